### rtl/core/linear_probe_hash_map_core_macros.svh
// ----------------------------------------------------------------------------
// Hash map assertion macros
// Assertion helpers used by the hash map core; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LPHM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPHM_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHM_ASSERT(label, clk, rst_n, prop, msg)
`define LPHM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/core/lphm_pkg.sv
// ----------------------------------------------------------------------------
// Hash map package
// Shared constants, types and the hash mixing constants.
// ----------------------------------------------------------------------------
package lphm_pkg;
	localparam int CAPACITY_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int KEY_W = 64;
	localparam int COUNT_W = 11;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE = 2'd1;
	localparam logic [1:0] MARK_TOMB = 2'd2;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MIX,
		S_MUL,
		S_MOD,
		S_READ,
		S_CHECK,
		S_WRITE,
		S_OUT
	} state_t;
endpackage

### rtl/core/linear_probe_hash_map_core.sv
// ----------------------------------------------------------------------------
// Linear probing hash map core
// Open-addressed map of 64-bit keys with tombstones, one request at a time.
// ----------------------------------------------------------------------------
// After reset the core sweeps the slot marks to empty, one slot per cycle,
// before it accepts its first transaction. A request then occupies the core,
// which stalls its input until the result has been taken past any output
// stall. One shared 32-bit multiplier does all the multiplications.
// It hashes the key in 32-bit partial products, three per 64-bit product.
// It then reduces the hash modulo the capacity: the high half is folded into
// the low half until it is zero, then a reciprocal multiply and a
// back-multiply give the remainder. Each probe step reads the registered
// table memory once.
`include "linear_probe_hash_map_core_macros.svh"

module linear_probe_hash_map_core #(
	parameter int CAPACITY = lphm_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = lphm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             req_type,
	input  logic [63:0]            key,
	input  logic [31:0]            value_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [31:0]            value_out,
	output logic [10:0]            live_count
);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] LAST_C = CW'(CAPACITY - 1);
	localparam int MOD_L = $clog2(CAPACITY);
	localparam int MOD_SH = MOD_L - 1;
	localparam logic [31:0] MOD_K = 32'((64'd1 << 32) % 64'(CAPACITY));
	localparam logic [31:0] MOD_M =
		32'(((64'((1 << MOD_L) - CAPACITY)) << 32) / 64'(CAPACITY) + 64'd1);
	localparam int COUNT_W_L = lphm_pkg::COUNT_W;

	logic [1:0]             mark_mem [CAPACITY];
	logic [63:0]            key_mem [CAPACITY];
	logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];

	lphm_pkg::state_t state_q, state_n;
	logic [CW-1:0] clr_q;
	logic [1:0] req_q;
	logic [63:0] key_q, h_q, mc_q;
	logic [VALUE_WIDTH-1:0] vin_q;
	logic [1:0] mround_q;
	logic [2:0] mstep_q;
	logic [63:0] acc_q;
	logic [1:0] modstep_q;
	logic [31:0] modt_q, quo_q;
	logic [IW-1:0] rem_q;
	logic [IW-1:0] pos_q, tpos_q;
	logic [CW-1:0] n_q;
	logic have_t_q, hit_q, empty_q;
	logic [1:0] rd_mark_q;
	logic [63:0] rd_key_q;
	logic [VALUE_WIDTH-1:0] rd_val_q;
	logic [COUNT_W_L-1:0] live_q, tomb_q;
	logic [1:0] status_q;
	logic [31:0] vout_q;

	logic [31:0] pa, pb;
	logic [63:0] prod;
	logic [31:0] quo_n;
	logic [IW-1:0] pos_inc;
	logic clr_done, probe_end, mul_last;

	assign in_stall = (state_q != lphm_pkg::S_IDLE);
	assign out_valid = (state_q == lphm_pkg::S_OUT);
	assign status = status_q;
	assign value_out = vout_q;
	assign live_count = live_q;

	// Partial product: step k selects halves a=k[1], b=k[0]; step 3 is the high
	// product which falls outside the 64-bit result and is skipped.
	always_comb begin
		pa = mstep_q[1] ? h_q[63:32] : h_q[31:0];
		pb = mstep_q[0] ? mc_q[63:32] : mc_q[31:0];
		if (state_q == lphm_pkg::S_MOD) begin
			case (modstep_q)
				2'd0: begin
					pa = h_q[63:32];
					pb = MOD_K;
				end
				2'd1: begin
					pa = h_q[31:0];
					pb = MOD_M;
				end
				default: begin
					pa = quo_q;
					pb = 32'(CAPACITY);
				end
			endcase
		end
	end

	assign prod = pa * pb;
	assign quo_n = (modt_q + ((h_q[31:0] - modt_q) >> 1)) >> MOD_SH;
	assign mul_last = (mstep_q == 3'd2);
	assign pos_inc = (CW'(pos_q) == LAST_C) ? '0 : pos_q + 1'b1;
	assign clr_done = (clr_q == LAST_C);
	assign probe_end = (n_q == LAST_C);

	always_comb begin
		state_n = state_q;
		case (state_q)
			lphm_pkg::S_CLEAR: begin
				if (clr_done) state_n = lphm_pkg::S_IDLE;
			end
			lphm_pkg::S_IDLE: begin
				if (in_valid) state_n = lphm_pkg::S_MIX;
			end
			lphm_pkg::S_MIX: begin
				if (mround_q == 2'd2) state_n = lphm_pkg::S_MOD;
				else state_n = lphm_pkg::S_MUL;
			end
			lphm_pkg::S_MUL: begin
				if (mul_last) state_n = lphm_pkg::S_MIX;
			end
			lphm_pkg::S_MOD: begin
				if (modstep_q == 2'd3) state_n = lphm_pkg::S_READ;
			end
			lphm_pkg::S_READ: state_n = lphm_pkg::S_CHECK;
			lphm_pkg::S_CHECK: begin
				if (rd_mark_q == lphm_pkg::MARK_LIVE && rd_key_q == key_q)
					state_n = lphm_pkg::S_WRITE;
				else if (rd_mark_q != lphm_pkg::MARK_LIVE && rd_mark_q != lphm_pkg::MARK_TOMB)
					state_n = lphm_pkg::S_WRITE;
				else if (probe_end) state_n = lphm_pkg::S_WRITE;
				else state_n = lphm_pkg::S_READ;
			end
			lphm_pkg::S_WRITE: state_n = lphm_pkg::S_OUT;
			lphm_pkg::S_OUT: begin
				if (!out_stall) state_n = lphm_pkg::S_IDLE;
			end
			default: state_n = lphm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lphm_pkg::S_CLEAR;
			clr_q <= '0;
			live_q <= '0;
			tomb_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == lphm_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == lphm_pkg::S_WRITE) begin
				if (req_q == lphm_pkg::REQ_INSERT && !hit_q && (have_t_q || empty_q)) begin
					live_q <= live_q + 1'b1;
					if (have_t_q && tomb_q != '0) tomb_q <= tomb_q - 1'b1;
				end else if (req_q == lphm_pkg::REQ_REMOVE && hit_q) begin
					if (live_q != '0) live_q <= live_q - 1'b1;
					tomb_q <= tomb_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lphm_pkg::S_IDLE: begin
				req_q <= req_type;
				key_q <= key;
				h_q <= key;
				vin_q <= VALUE_WIDTH'(value_in);
				mround_q <= '0;
			end
			lphm_pkg::S_MIX: begin
				case (mround_q)
					2'd0: begin h_q <= h_q ^ (h_q >> 30); mc_q <= lphm_pkg::MIX_C1; end
					2'd1: begin h_q <= h_q ^ (h_q >> 27); mc_q <= lphm_pkg::MIX_C2; end
					default: h_q <= h_q ^ (h_q >> 31);
				endcase
				mround_q <= mround_q + 1'b1;
				mstep_q <= '0;
				acc_q <= '0;
				modstep_q <= '0;
			end
			lphm_pkg::S_MUL: begin
				case (mstep_q)
					3'd0: acc_q <= prod;
					3'd1: acc_q <= acc_q + {prod[31:0], 32'd0};
					default: begin
						acc_q <= '0;
						h_q <= acc_q + {prod[31:0], 32'd0};
					end
				endcase
				mstep_q <= mstep_q + 1'b1;
			end
			lphm_pkg::S_MOD: begin
				case (modstep_q)
					2'd0: begin
						h_q <= prod + {32'd0, h_q[31:0]};
						if (h_q[63:32] == 32'd0) modstep_q <= 2'd1;
					end
					2'd1: begin
						modt_q <= prod[63:32];
						modstep_q <= 2'd2;
					end
					2'd2: begin
						quo_q <= quo_n;
						modstep_q <= 2'd3;
					end
					default: rem_q <= IW'(h_q[31:0] - prod[31:0]);
				endcase
				n_q <= '0;
				have_t_q <= 1'b0;
				hit_q <= 1'b0;
				empty_q <= 1'b0;
				tpos_q <= '0;
			end
			lphm_pkg::S_READ: begin
				if (n_q == '0) pos_q <= rem_q;
			end
			lphm_pkg::S_CHECK: begin
				if (rd_mark_q == lphm_pkg::MARK_LIVE) begin
					if (rd_key_q == key_q) hit_q <= 1'b1;
				end else if (rd_mark_q == lphm_pkg::MARK_TOMB) begin
					if (!have_t_q) begin
						have_t_q <= 1'b1;
						tpos_q <= pos_q;
					end
				end else begin
					empty_q <= 1'b1;
				end
				if (!(rd_mark_q == lphm_pkg::MARK_LIVE && rd_key_q == key_q) &&
				    (rd_mark_q == lphm_pkg::MARK_LIVE || rd_mark_q == lphm_pkg::MARK_TOMB) &&
				    !probe_end)
					pos_q <= pos_inc;
				n_q <= n_q + 1'b1;
			end
			lphm_pkg::S_WRITE: begin
				vout_q <= '0;
				status_q <= lphm_pkg::ST_NOT_FOUND;
				if (req_q == lphm_pkg::REQ_INSERT) begin
					if (hit_q || have_t_q || empty_q) status_q <= lphm_pkg::ST_OK;
					else status_q <= lphm_pkg::ST_FULL;
				end else if (req_q == lphm_pkg::REQ_REMOVE) begin
					if (hit_q) status_q <= lphm_pkg::ST_OK;
				end else if (hit_q) begin
					status_q <= lphm_pkg::ST_OK;
					vout_q <= 32'(rd_val_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Table memory: one read address per cycle, registered read data.
	logic [IW-1:0] rd_addr;
	assign rd_addr = (n_q == '0) ? rem_q : pos_q;

	always_ff @(posedge clk) begin
		if (state_q == lphm_pkg::S_READ) begin
			rd_mark_q <= mark_mem[rd_addr];
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	logic ins_new;
	logic [IW-1:0] dst;
	assign ins_new = (req_q == lphm_pkg::REQ_INSERT) && !hit_q && (have_t_q || empty_q);
	assign dst = have_t_q ? tpos_q : pos_q;

	always_ff @(posedge clk) begin
		if (state_q == lphm_pkg::S_CLEAR) begin
			mark_mem[IW'(clr_q)] <= lphm_pkg::MARK_EMPTY;
		end else if (state_q == lphm_pkg::S_WRITE) begin
			if (ins_new) begin
				mark_mem[dst] <= lphm_pkg::MARK_LIVE;
			end else if (req_q == lphm_pkg::REQ_REMOVE && hit_q) begin
				mark_mem[pos_q] <= lphm_pkg::MARK_TOMB;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lphm_pkg::S_WRITE && req_q == lphm_pkg::REQ_INSERT &&
		    (hit_q || ins_new)) begin
			key_mem[hit_q ? pos_q : dst] <= key_q;
			val_mem[hit_q ? pos_q : dst] <= vin_q;
		end
	end

	`LPHM_ASSERT(a_stall_busy, clk, arst_n, (state_q != lphm_pkg::S_IDLE) |-> in_stall, "busy core must stall input")
	`LPHM_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(status)), "result changed while stalled")
	`LPHM_ASSERT(a_full_ins, clk, arst_n, (out_valid && status == lphm_pkg::ST_FULL) |-> (req_q == lphm_pkg::REQ_INSERT), "full status on non-insert")
	`LPHM_ASSERT(a_vout_zero, clk, arst_n, (out_valid && status != lphm_pkg::ST_OK) |-> (value_out == 32'd0), "value on failed request")
endmodule

### tb/linear_probe_hash_map_core_tb.sv
// ----------------------------------------------------------------------------
// Hash map core testbench
// Drives lookups, inserts, removes and request code 3 on the request channel
// and checks every response against a behavioral model of the probed table.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_core_tb;
	localparam int CAP = lphm_pkg::CAPACITY_DEF;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] key;
		logic [31:0] value_in;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value_out;
		logic [10:0] live_count;
	} response_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [63:0] key;
	logic [31:0] value_in;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] value_out;
	logic [10:0] live_count;

	linear_probe_hash_map_core DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .key(key), .value_in(value_in),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.value_out(value_out), .live_count(live_count)
	);

	logic [63:0] tbl_key[CAP];
	logic [31:0] tbl_val[CAP];
	logic [1:0]  tbl_mark[CAP];
	int unsigned live_n;
	int unsigned tomb_n;

	request_t  pending_reqs[$];
	response_t expected_resps[$];
	logic [63:0] key_pool[$];
	int  errors = 0;
	int  send_idle_pct = 22;
	int  recv_idle_pct = 86;
	bit  hold_send = 0;

	function automatic logic [63:0] splitmix_mix(logic [63:0] x);
		x = x ^ (x >> 30);
		x = x * lphm_pkg::MIX_C1;
		x = x ^ (x >> 27);
		x = x * lphm_pkg::MIX_C2;
		x = x ^ (x >> 31);
		return x;
	endfunction

	function automatic response_t apply_request(request_t r);
		response_t rsp;
		int pos;
		int tpos;
		bit have_t;
		bit hit;
		bit ended;
		pos = int'(splitmix_mix(r.key) % CAP);
		have_t = 0;
		tpos = 0;
		hit = 0;
		ended = 0;
		rsp = '0;
		rsp.status = lphm_pkg::ST_NOT_FOUND;
		for (int n = 0; n < CAP; n++) begin
			if (tbl_mark[pos] == lphm_pkg::MARK_LIVE) begin
				if (tbl_key[pos] == r.key) begin
					hit = 1;
					break;
				end
			end else if (tbl_mark[pos] == lphm_pkg::MARK_TOMB) begin
				if (!have_t) begin
					have_t = 1;
					tpos = pos;
				end
			end else begin
				ended = 1;
				break;
			end
			pos = (pos + 1) % CAP;
		end
		if (r.req_type == lphm_pkg::REQ_INSERT) begin
			if (hit) begin
				tbl_val[pos] = r.value_in;
				rsp.status = lphm_pkg::ST_OK;
			end else if (have_t || ended) begin
				if (have_t) begin
					pos = tpos;
					if (tomb_n > 0) tomb_n--;
				end
				tbl_key[pos] = r.key;
				tbl_val[pos] = r.value_in;
				tbl_mark[pos] = lphm_pkg::MARK_LIVE;
				live_n++;
				rsp.status = lphm_pkg::ST_OK;
			end else begin
				rsp.status = lphm_pkg::ST_FULL;
			end
		end else if (r.req_type == lphm_pkg::REQ_REMOVE) begin
			if (hit) begin
				tbl_mark[pos] = lphm_pkg::MARK_TOMB;
				if (live_n > 0) live_n--;
				tomb_n++;
				rsp.status = lphm_pkg::ST_OK;
			end
		end else if (hit) begin
			rsp.value_out = tbl_val[pos];
			rsp.status = lphm_pkg::ST_OK;
		end
		rsp.live_count = live_n[10:0];
		return rsp;
	endfunction

	function automatic logic [63:0] rand_key();
		if (key_pool.size() > 0 && $urandom_range(99) < 75)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		return {$urandom(), $urandom()};
	endfunction

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= '0;
			key <= '0;
			value_in <= '0;
		end else if (!in_valid || !in_stall) begin
			if (pending_reqs.size() > 0 && !hold_send
					&& $urandom_range(99) >= send_idle_pct) begin
				request_t r;
				r = pending_reqs.pop_front();
				expected_resps.push_back(apply_request(r));
				in_valid <= 1'b1;
				req_type <= r.req_type;
				key <= r.key;
				value_in <= r.value_in;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_resps.size() == 0) begin
					$error("unexpected response: status %0d", status);
					errors++;
				end else begin
					response_t e;
					e = expected_resps.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, status);
						errors++;
					end
					if (value_out !== e.value_out) begin
						$error("value_out: expected %h, actual %h", e.value_out,
							value_out);
						errors++;
					end
					if (live_count !== e.live_count) begin
						$error("live_count: expected %0d, actual %0d", e.live_count,
							live_count);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic add_req(logic [1:0] t, logic [63:0] k, logic [31:0] v);
		request_t r;
		r.req_type = t;
		r.key = k;
		r.value_in = v;
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
			@(posedge clk);
	endtask

	task automatic add_random(int n, int fill_bias);
		logic [1:0] t;
		logic [63:0] k;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < fill_bias) t = lphm_pkg::REQ_INSERT;
			else if (pick < fill_bias + 25) t = lphm_pkg::REQ_LOOKUP;
			else if (pick < 97) t = lphm_pkg::REQ_REMOVE;
			else t = 2'd3;
			k = rand_key();
			if (t == lphm_pkg::REQ_INSERT && key_pool.size() < 400) key_pool.push_back(k);
			add_req(t, k, $urandom());
		end
	endtask

	initial begin
		for (int i = 0; i < CAP; i++) begin
			tbl_mark[i] = lphm_pkg::MARK_EMPTY;
			tbl_key[i] = '0;
			tbl_val[i] = '0;
		end
		live_n = 0;
		tomb_n = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		add_req(lphm_pkg::REQ_LOOKUP, 64'd0, 32'hffffffff);
		add_req(lphm_pkg::REQ_REMOVE, 64'd0, 32'd0);
		add_req(lphm_pkg::REQ_INSERT, 64'd0, 32'd0);
		add_req(lphm_pkg::REQ_INSERT, 64'hffffffffffffffff, 32'hffffffff);
		add_req(lphm_pkg::REQ_LOOKUP, 64'd0, 32'd0);
		add_req(lphm_pkg::REQ_LOOKUP, 64'hffffffffffffffff, 32'd0);
		add_req(lphm_pkg::REQ_INSERT, 64'd0, 32'h5a5a5a5a);
		add_req(2'd3, 64'd0, 32'd7);
		add_req(lphm_pkg::REQ_REMOVE, 64'd0, 32'd0);
		add_req(lphm_pkg::REQ_LOOKUP, 64'd0, 32'd0);
		add_req(lphm_pkg::REQ_REMOVE, 64'd0, 32'd0);
		add_req(lphm_pkg::REQ_INSERT, 64'd0, 32'h12345678);
		add_req(lphm_pkg::REQ_INSERT, 64'h8000000000000000, 32'h80000000);
		add_req(lphm_pkg::REQ_LOOKUP, 64'h8000000000000000, 32'd0);
		add_req(lphm_pkg::REQ_REMOVE, 64'hffffffffffffffff, 32'd0);
		add_req(lphm_pkg::REQ_LOOKUP, 64'hffffffffffffffff, 32'd0);
		key_pool.push_back(64'd0);
		key_pool.push_back(64'hffffffffffffffff);
		key_pool.push_back(64'h8000000000000000);

		add_random(260, 45);
		drain();

		// The sender is held off, then the send and receive idle rates are swapped.
		hold_send = 1;
		repeat (20) @(posedge clk);
		hold_send = 0;
		send_idle_pct = 86;
		recv_idle_pct = 22;
		add_random(260, 40);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random(260, 40);
		drain();
		repeat (4 * CAP) @(posedge clk);

		if (errors == 0 && expected_resps.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#(20 * 20000000);
		$display("Mismatches found");
		$finish;
	end
endmodule

### linear_probe_hash_map_core.f
+incdir+rtl/core
rtl/core/lphm_pkg.sv
rtl/core/linear_probe_hash_map_core.sv
tb/linear_probe_hash_map_core_tb.sv
